### hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // Default number of queue entries
  localparam int unsigned DefaultDepth = 16;

  // Fixed field widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned CountW = 5;

  typedef logic [CountW-1:0] count_t;

  // Transaction kind
  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Input transaction
  typedef struct packed {
    mode_e                     mode;
    logic signed [DataW-1:0]   data_in;
    logic        [PrioW-1:0]   priority_in;
  } in_t;

  // Result transaction
  typedef struct packed {
    status_e                   status;
    logic signed [DataW-1:0]   data_out;
    logic        [PrioW-1:0]   priority_out;
    count_t                    count;
  } out_t;

  // One stored entry
  typedef struct packed {
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } entry_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ins;
  } cell_ctrl_t;

endpackage

### hw/rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  logic                left_ge_i,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  output spq_pkg::entry_t     entry_o,
  output logic                ge_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // Entry stays ahead of the new one when its priority is equal or higher
  assign ge_o = occupied_i && (entry_q.prio >= ctrl_i.ins.prio);

  // Local shift: hold, take the new entry, take the left or right neighbour
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (!ge_o) begin
        if (left_ge_i) begin
          entry_d = ctrl_i.ins;
        end else begin
          entry_d = left_i;
        end
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### hw/rtl/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Sorted priority queue built as a row of DEPTH entry cells.
// The result of an accepted transaction is registered and shows in the next cycle.
// Throughput: one transaction per cycle while in_stall_o is low; every cell compares
// and shifts locally in the same cycle, so the row update bounds the rate.
// Reset: occupancy and result valid cleared; entry contents are not reset.

module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::out_t out_data_o
);

  localparam int unsigned OccW = $clog2(DEPTH + 1);

  logic [OccW-1:0] occ_q, occ_d;
  logic            out_valid_q;
  spq_pkg::out_t   out_q, out_d;

  logic accept, full, empty, do_enq, do_deq;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     cell_entry [DEPTH];
  logic                cell_ge    [DEPTH];

  // Handshake: the result register frees up when its transaction leaves
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full   = (occ_q == OccW'(DEPTH));
  assign empty  = (occ_q == '0);
  assign do_enq = accept && (in_data_i.mode == spq_pkg::MODE_ENQ) && !full;
  assign do_deq = accept && (in_data_i.mode == spq_pkg::MODE_DEQ) && !empty;

  // Control broadcast to the cell row
  always_comb begin
    ctrl.enq      = do_enq;
    ctrl.deq      = do_deq;
    ctrl.ins.data = in_data_i.data_in;
    ctrl.ins.prio = in_data_i.priority_in;
  end

  // Cell row, slot 0 at the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            left_ge;

    if (i == 0) begin : g_first
      assign left    = ctrl.ins;
      assign left_ge = 1'b1;
    end else begin : g_mid
      assign left    = cell_entry[i-1];
      assign left_ge = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = cell_entry[i];
    end else begin : g_inner
      assign right = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (OccW'(i) < occ_q),
      .left_ge_i  (left_ge),
      .left_i     (left),
      .right_i    (right),
      .entry_o    (cell_entry[i]),
      .ge_o       (cell_ge[i])
    );
  end

  // Occupancy update
  always_comb begin
    occ_d = occ_q;
    if (do_enq) begin
      occ_d = occ_q + OccW'(1);
    end else if (do_deq) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  // Result formation
  always_comb begin
    out_d.status       = spq_pkg::STATUS_DONE;
    out_d.data_out     = '0;
    out_d.priority_out = '0;
    out_d.count        = spq_pkg::count_t'(occ_d);
    unique case (in_data_i.mode)
      spq_pkg::MODE_ENQ: begin
        if (full) begin
          out_d.status = spq_pkg::STATUS_FULL;
        end
      end
      spq_pkg::MODE_DEQ: begin
        if (empty) begin
          out_d.status = spq_pkg::STATUS_EMPTY;
        end else begin
          out_d.data_out     = cell_entry[0].data;
          out_d.priority_out = cell_entry[0].prio;
        end
      end
      default: out_d.status = spq_pkg::STATUS_DONE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Occupancy never passes the store size
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= OccW'(DEPTH))
    else $error("occupancy above depth");

  // An accepted transaction always leaves a result behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> out_valid_q)
    else $error("result missing after accepted transaction");

  // A successful insert grows the queue by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_enq |=> occ_q == $past(occ_q) + OccW'(1))
    else $error("insert did not grow occupancy");

  // A dequeue on an empty queue reports empty with a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.mode == spq_pkg::MODE_DEQ) && empty)
      |=> (out_q.status == spq_pkg::STATUS_EMPTY) && (out_q.count == '0))
    else $error("empty dequeue misreported");

endmodule
